[design/contour_to_plotter_path_densifier_unit_defines.svh]
// Assertion macros shared by the densifier RTL.
`ifndef CONTOUR_TO_PLOTTER_PATH_DENSIFIER_UNIT_DEFINES_SVH
`define CONTOUR_TO_PLOTTER_PATH_DENSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/cpd_pkg.sv]
package cpd_pkg;

  localparam int COORD_BITS = 12;
  localparam int DEPTH_W    = 14;
  localparam int ACROSS_W   = 13;
  localparam int HEIGHT_W   = 14;
  localparam int POS_W      = 16;
  localparam int MAG_W      = 15;
  localparam int SCALE_W    = 14;
  localparam int MUL_W      = 28;
  localparam int PROD_W     = 56;
  localparam int QUO_W      = 29;
  localparam int ROOT_W     = 15;
  localparam int K_W        = 4;

  localparam logic [SCALE_W-1:0] ACROSS_SPAN = 14'd7680;
  localparam logic [SCALE_W-1:0] HEIGHT_SPAN = 14'd10240;
  localparam logic signed [POS_W-1:0] ACROSS_MIN = -16'sd3840;
  localparam logic signed [POS_W-1:0] HEIGHT_MIN = 16'sd2560;
  localparam logic [DEPTH_W-1:0] DEPTH_BOARD = 14'd10240;
  localparam logic [DEPTH_W-1:0] DEPTH_LIFT  = 14'd12288;
  localparam logic [K_W-1:0] MAX_FILLS = 4'd12;

  typedef enum logic [1:0] {
    KIND_FILL    = 2'd0,
    KIND_CONTOUR = 2'd1,
    KIND_LIFT    = 2'd2
  } point_kind_t;

  typedef enum logic [1:0] {
    REG_ORIGIN_X = 2'd0,
    REG_ORIGIN_Y = 2'd1,
    REG_EXTENT_X = 2'd2,
    REG_EXTENT_Y = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    GOAL_LIFT_IN  = 2'd0,
    GOAL_BOARD    = 2'd1,
    GOAL_LIFT_OUT = 2'd2
  } goal_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SC_MUL,
    S_SC_DIV,
    S_SC_WAIT,
    S_GOAL,
    S_D2_Y,
    S_D2_Z,
    S_D2_SUM,
    S_CHECK,
    S_FL_MUL_A,
    S_FL_MUL_A2,
    S_FL_DIV,
    S_FL_DIV_WAIT,
    S_FL_SQRT_WAIT,
    S_EMIT_FILL,
    S_EMIT_TGT
  } state_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  starts_contour;
    logic                  ends_contour;
  } in_item_t;

  typedef struct packed {
    logic [DEPTH_W-1:0]         depth_cm;
    logic signed [ACROSS_W-1:0] across_cm;
    logic [HEIGHT_W-1:0]        height_cm;
    logic [1:0]                 point_kind;
    logic                       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic              is_sqrt;
    logic [PROD_W-1:0] num;
    logic [MUL_W-1:0]  den;
  } unit_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] result;
  } unit_rsp_t;

endpackage

[design/contour_to_plotter_path_densifier_unit.sv]
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    cpd_pkg::in_item_t
// out_      output     out_valid / out_ready  cpd_pkg::out_item_t
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One point is taken at a time; in_ready is high only while the sequencer is idle.
// Scaling runs a 29-step divide per axis, which is skipped when that extent is zero.
// Each fill point then needs, per axis, a 29-step divide and a 15-step square root.
// Results leave through one output register, so a stalled output stops the sequencer only
// when the next result is ready. Reset is synchronous and needs no clearing pass.
`include "contour_to_plotter_path_densifier_unit_defines.svh"

module contour_to_plotter_path_densifier_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  cpd_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output cpd_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [cpd_pkg::COORD_BITS-1:0]  cfg_data
);

  localparam int CB = cpd_pkg::COORD_BITS;

  cpd_pkg::state_t state_r, state_nxt;
  cpd_pkg::goal_t  goal_r, goal_nxt;

  logic [CB-1:0] org_x_r, org_y_r, ext_x_r, ext_y_r;
  logic [CB-1:0] px_r, px_nxt, py_r, py_nxt;
  logic          last_r, last_nxt;
  logic          axis_r, axis_nxt;
  logic [cpd_pkg::K_W-1:0] k_r, k_nxt;

  logic signed [cpd_pkg::POS_W-1:0] across_r, across_nxt, height_r, height_nxt;
  logic signed [cpd_pkg::POS_W-1:0] prev_across_r, prev_across_nxt;
  logic signed [cpd_pkg::POS_W-1:0] prev_height_r, prev_height_nxt;
  logic [cpd_pkg::DEPTH_W-1:0]      prev_depth_r, prev_depth_nxt;
  logic                             have_prev_r, have_prev_nxt;
  logic signed [cpd_pkg::POS_W-1:0] off_y_r, off_y_nxt, off_z_r, off_z_nxt;

  logic [cpd_pkg::MUL_W-1:0]  mul_a, mul_b, d2_r, d2_nxt;
  logic [cpd_pkg::PROD_W-1:0] prod_r;

  cpd_pkg::out_item_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  cpd_pkg::unit_req_t req;
  cpd_pkg::unit_rsp_t rsp;

  logic [CB-1:0]      pix_s, org_s, ext_s, n_off, n_cl;
  logic [cpd_pkg::SCALE_W-1:0] span_s, sc_q;
  logic               sc_store;
  logic signed [cpd_pkg::POS_W-1:0] dy, dz, off_m;
  logic [cpd_pkg::MAG_W-1:0] dy_mag, dz_mag, mag_s, half_t, m_val;
  logic               neg_s;
  logic [7:0]         k_sq;
  logic               more_fills;
  logic               emit_ok;
  logic               final_goal;
  logic [cpd_pkg::DEPTH_W-1:0] goal_depth;
  cpd_pkg::point_kind_t        goal_kind;

  cpd_divsqrt u_divsqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign pix_s  = axis_r ? py_r : px_r;
  assign org_s  = axis_r ? org_y_r : org_x_r;
  assign ext_s  = axis_r ? ext_y_r : ext_x_r;
  assign span_s = axis_r ? cpd_pkg::HEIGHT_SPAN : cpd_pkg::ACROSS_SPAN;
  assign n_off  = (pix_s > org_s) ? pix_s - org_s : '0;
  assign n_cl   = (n_off > ext_s) ? ext_s : n_off;

  assign dy     = across_r - prev_across_r;
  assign dz     = height_r - prev_height_r;
  assign dy_mag = dy[cpd_pkg::POS_W-1] ? cpd_pkg::MAG_W'(-dy) : cpd_pkg::MAG_W'(dy);
  assign dz_mag = dz[cpd_pkg::POS_W-1] ? cpd_pkg::MAG_W'(-dz) : cpd_pkg::MAG_W'(dz);
  assign mag_s  = axis_r ? dz_mag : dy_mag;
  assign neg_s  = axis_r ? dz[cpd_pkg::POS_W-1] : dy[cpd_pkg::POS_W-1];
  assign half_t = cpd_pkg::MAG_W'(({1'b0, rsp.result[cpd_pkg::ROOT_W-1:0]} + 16'd1) >> 1);
  assign m_val  = (half_t > mag_s) ? mag_s : half_t;
  assign off_m  = neg_s ? -$signed({1'b0, m_val}) : $signed({1'b0, m_val});

  assign k_sq       = {4'b0, k_r} * {4'b0, k_r};
  assign more_fills = (k_r <= cpd_pkg::MAX_FILLS) && ({k_sq, 20'b0} < d2_r);
  assign emit_ok    = !out_valid_r || out_ready;
  assign final_goal = (goal_r == cpd_pkg::GOAL_LIFT_OUT) ||
                      ((goal_r == cpd_pkg::GOAL_BOARD) && !last_r);
  assign goal_depth = (goal_r == cpd_pkg::GOAL_BOARD) ? cpd_pkg::DEPTH_BOARD
                                                      : cpd_pkg::DEPTH_LIFT;
  assign goal_kind  = (goal_r == cpd_pkg::GOAL_BOARD) ? cpd_pkg::KIND_CONTOUR
                                                      : cpd_pkg::KIND_LIFT;

  assign sc_store = ((state_r == cpd_pkg::S_SC_DIV) && (ext_s == '0)) ||
                    ((state_r == cpd_pkg::S_SC_WAIT) && rsp.done);
  assign sc_q     = (state_r == cpd_pkg::S_SC_WAIT) ? rsp.result[cpd_pkg::SCALE_W-1:0] : '0;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      cpd_pkg::S_SC_MUL: begin
        mul_a = cpd_pkg::MUL_W'(n_cl);
        mul_b = cpd_pkg::MUL_W'(span_s);
      end
      cpd_pkg::S_D2_Y: begin
        mul_a = cpd_pkg::MUL_W'(dy_mag);
        mul_b = cpd_pkg::MUL_W'(dy_mag);
      end
      cpd_pkg::S_D2_Z: begin
        mul_a = cpd_pkg::MUL_W'(dz_mag);
        mul_b = cpd_pkg::MUL_W'(dz_mag);
      end
      cpd_pkg::S_FL_MUL_A: begin
        mul_a = cpd_pkg::MUL_W'(mag_s);
        mul_b = cpd_pkg::MUL_W'(k_r);
      end
      cpd_pkg::S_FL_MUL_A2: begin
        mul_a = cpd_pkg::MUL_W'({prod_r[16:0], 10'b0});
        mul_b = cpd_pkg::MUL_W'({prod_r[16:0], 10'b0});
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    req.start   = 1'b0;
    req.is_sqrt = 1'b0;
    req.num     = '0;
    req.den     = '0;
    unique case (state_r)
      cpd_pkg::S_SC_DIV: begin
        req.start = (ext_s != '0);
        req.num   = cpd_pkg::PROD_W'({prod_r[26:0], 1'b0}) + cpd_pkg::PROD_W'(ext_s);
        req.den   = cpd_pkg::MUL_W'({ext_s, 1'b0});
      end
      cpd_pkg::S_FL_DIV: begin
        req.start = 1'b1;
        req.num   = {prod_r[cpd_pkg::PROD_W-3:0], 2'b00};
        req.den   = d2_r;
      end
      cpd_pkg::S_FL_DIV_WAIT: begin
        req.start   = rsp.done;
        req.is_sqrt = 1'b1;
        req.num     = cpd_pkg::PROD_W'(rsp.result);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cpd_pkg::S_IDLE: begin
        if (in_valid && !(in_data.starts_contour && in_data.ends_contour)) begin
          state_nxt = cpd_pkg::S_SC_MUL;
        end
      end
      cpd_pkg::S_SC_MUL: state_nxt = cpd_pkg::S_SC_DIV;
      cpd_pkg::S_SC_DIV: begin
        if (ext_s == '0) begin
          state_nxt = axis_r ? cpd_pkg::S_GOAL : cpd_pkg::S_SC_MUL;
        end else begin
          state_nxt = cpd_pkg::S_SC_WAIT;
        end
      end
      cpd_pkg::S_SC_WAIT: begin
        if (rsp.done) begin
          state_nxt = axis_r ? cpd_pkg::S_GOAL : cpd_pkg::S_SC_MUL;
        end
      end
      cpd_pkg::S_GOAL: state_nxt = have_prev_r ? cpd_pkg::S_D2_Y : cpd_pkg::S_EMIT_TGT;
      cpd_pkg::S_D2_Y: state_nxt = cpd_pkg::S_D2_Z;
      cpd_pkg::S_D2_Z: state_nxt = cpd_pkg::S_D2_SUM;
      cpd_pkg::S_D2_SUM: state_nxt = cpd_pkg::S_CHECK;
      cpd_pkg::S_CHECK: state_nxt = more_fills ? cpd_pkg::S_FL_MUL_A : cpd_pkg::S_EMIT_TGT;
      cpd_pkg::S_FL_MUL_A: state_nxt = cpd_pkg::S_FL_MUL_A2;
      cpd_pkg::S_FL_MUL_A2: state_nxt = cpd_pkg::S_FL_DIV;
      cpd_pkg::S_FL_DIV: state_nxt = cpd_pkg::S_FL_DIV_WAIT;
      cpd_pkg::S_FL_DIV_WAIT: begin
        if (rsp.done) begin
          state_nxt = cpd_pkg::S_FL_SQRT_WAIT;
        end
      end
      cpd_pkg::S_FL_SQRT_WAIT: begin
        if (rsp.done) begin
          state_nxt = axis_r ? cpd_pkg::S_EMIT_FILL : cpd_pkg::S_FL_MUL_A;
        end
      end
      cpd_pkg::S_EMIT_FILL: begin
        if (emit_ok) begin
          state_nxt = cpd_pkg::S_CHECK;
        end
      end
      cpd_pkg::S_EMIT_TGT: begin
        if (emit_ok) begin
          state_nxt = final_goal ? cpd_pkg::S_IDLE : cpd_pkg::S_GOAL;
        end
      end
      default: state_nxt = cpd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    px_nxt          = px_r;
    py_nxt          = py_r;
    last_nxt        = last_r;
    axis_nxt        = axis_r;
    k_nxt           = k_r;
    goal_nxt        = goal_r;
    across_nxt      = across_r;
    height_nxt      = height_r;
    prev_across_nxt = prev_across_r;
    prev_height_nxt = prev_height_r;
    prev_depth_nxt  = prev_depth_r;
    have_prev_nxt   = have_prev_r;
    off_y_nxt       = off_y_r;
    off_z_nxt       = off_z_r;
    d2_nxt          = d2_r;
    out_nxt         = out_r;
    out_valid_nxt   = out_valid_r && !out_ready;

    if (state_r == cpd_pkg::S_IDLE && in_valid) begin
      px_nxt    = in_data.pixel_x;
      py_nxt    = in_data.pixel_y;
      last_nxt  = in_data.ends_contour;
      axis_nxt  = 1'b0;
      goal_nxt  = in_data.starts_contour ? cpd_pkg::GOAL_LIFT_IN : cpd_pkg::GOAL_BOARD;
    end

    if (sc_store) begin
      if (axis_r) begin
        height_nxt = $signed({2'b00, sc_q}) + cpd_pkg::HEIGHT_MIN;
      end else begin
        across_nxt = $signed({2'b00, sc_q}) + cpd_pkg::ACROSS_MIN;
        axis_nxt   = 1'b1;
      end
    end

    unique case (state_r)
      cpd_pkg::S_GOAL: k_nxt = 4'd1;
      cpd_pkg::S_D2_Z: d2_nxt = prod_r[cpd_pkg::MUL_W-1:0];
      cpd_pkg::S_D2_SUM: d2_nxt = d2_r + prod_r[cpd_pkg::MUL_W-1:0];
      cpd_pkg::S_CHECK: axis_nxt = 1'b0;
      cpd_pkg::S_FL_SQRT_WAIT: begin
        if (rsp.done) begin
          if (axis_r) begin
            off_z_nxt = off_m;
          end else begin
            off_y_nxt = off_m;
            axis_nxt  = 1'b1;
          end
        end
      end
      cpd_pkg::S_EMIT_FILL: begin
        if (emit_ok) begin
          out_valid_nxt       = 1'b1;
          out_nxt.depth_cm    = prev_depth_r;
          out_nxt.across_cm   = cpd_pkg::ACROSS_W'(prev_across_r + off_y_r);
          out_nxt.height_cm   = cpd_pkg::HEIGHT_W'(prev_height_r + off_z_r);
          out_nxt.point_kind  = cpd_pkg::KIND_FILL;
          out_nxt.last_of_run = 1'b0;
          k_nxt               = k_r + 4'd1;
        end
      end
      cpd_pkg::S_EMIT_TGT: begin
        if (emit_ok) begin
          out_valid_nxt       = 1'b1;
          out_nxt.depth_cm    = goal_depth;
          out_nxt.across_cm   = cpd_pkg::ACROSS_W'(across_r);
          out_nxt.height_cm   = cpd_pkg::HEIGHT_W'(height_r);
          out_nxt.point_kind  = goal_kind;
          out_nxt.last_of_run = final_goal;
          prev_depth_nxt      = goal_depth;
          prev_across_nxt     = across_r;
          prev_height_nxt     = height_r;
          have_prev_nxt       = 1'b1;
          goal_nxt = (goal_r == cpd_pkg::GOAL_LIFT_IN) ? cpd_pkg::GOAL_BOARD
                                                       : cpd_pkg::GOAL_LIFT_OUT;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= cpd_pkg::S_IDLE;
      out_valid_r   <= 1'b0;
      have_prev_r   <= 1'b0;
      prev_depth_r  <= '0;
      prev_across_r <= '0;
      prev_height_r <= '0;
      org_x_r       <= '0;
      org_y_r       <= '0;
      ext_x_r       <= '1;
      ext_y_r       <= '1;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      have_prev_r   <= have_prev_nxt;
      prev_depth_r  <= prev_depth_nxt;
      prev_across_r <= prev_across_nxt;
      prev_height_r <= prev_height_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          cpd_pkg::REG_ORIGIN_X: org_x_r <= cfg_data;
          cpd_pkg::REG_ORIGIN_Y: org_y_r <= cfg_data;
          cpd_pkg::REG_EXTENT_X: ext_x_r <= cfg_data;
          cpd_pkg::REG_EXTENT_Y: ext_y_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    last_r   <= last_nxt;
    axis_r   <= axis_nxt;
    k_r      <= k_nxt;
    goal_r   <= goal_nxt;
    across_r <= across_nxt;
    height_r <= height_nxt;
    off_y_r  <= off_y_nxt;
    off_z_r  <= off_z_nxt;
    d2_r     <= d2_nxt;
    prod_r   <= mul_a * mul_b;
    out_r    <= out_nxt;
  end

  assign in_ready  = (state_r == cpd_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `CPD_ASSERT_IMP(a_fill_not_last,
    out_valid && (out_data.point_kind == cpd_pkg::KIND_FILL), !out_data.last_of_run,
    "fill point flagged as last result of a transaction")
  `CPD_ASSERT_IMP(a_done_when_waiting, rsp.done,
    (state_r == cpd_pkg::S_SC_WAIT) || (state_r == cpd_pkg::S_FL_DIV_WAIT) ||
    (state_r == cpd_pkg::S_FL_SQRT_WAIT),
    "arithmetic unit finished while the sequencer was not waiting")
  `CPD_ASSERT_IMP(a_start_when_free, req.start, !rsp.busy,
    "arithmetic unit started while busy")
  `CPD_ASSERT_NEXT(a_fill_count,
    (state_r == cpd_pkg::S_EMIT_FILL) && emit_ok, k_r <= cpd_pkg::MAX_FILLS + 4'd1,
    "more fill points than allowed between two targets")

endmodule

[design/cpd_divsqrt.sv]
module cpd_divsqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  cpd_pkg::unit_req_t  req,
  output cpd_pkg::unit_rsp_t  rsp
);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic                       sqrt_r, sqrt_nxt;
  logic [4:0]                 cnt_r, cnt_nxt;
  logic [cpd_pkg::PROD_W-1:0] num_r, num_nxt;
  logic [cpd_pkg::MUL_W-1:0]  den_r, den_nxt;
  logic [29:0]                rem_r, rem_nxt;
  logic [cpd_pkg::QUO_W-1:0]  quo_r, quo_nxt;
  logic [29:0]                d_trial;
  logic [29:0]                s_rem;
  logic [29:0]                s_trial;

  assign d_trial = {rem_r[28:0], num_r[cpd_pkg::PROD_W-1]};
  assign s_rem   = {rem_r[27:0], num_r[cpd_pkg::PROD_W-1 -: 2]};
  assign s_trial = {quo_r[27:0], 2'b01};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sqrt_nxt = sqrt_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (!busy_r && req.start) begin
      busy_nxt = 1'b1;
      sqrt_nxt = req.is_sqrt;
      den_nxt  = req.den;
      quo_nxt  = '0;
      if (req.is_sqrt) begin
        cnt_nxt = 5'd15;
        rem_nxt = '0;
        num_nxt = {req.num[29:0], 26'b0};
      end else begin
        cnt_nxt = 5'd29;
        rem_nxt = {3'b0, req.num[55:29]};
        num_nxt = {req.num[28:0], 27'b0};
      end
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      if (sqrt_r) begin
        num_nxt = {num_r[cpd_pkg::PROD_W-3:0], 2'b00};
        if (s_rem >= s_trial) begin
          rem_nxt = s_rem - s_trial;
          quo_nxt = {quo_r[cpd_pkg::QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt = s_rem;
          quo_nxt = {quo_r[cpd_pkg::QUO_W-2:0], 1'b0};
        end
      end else begin
        num_nxt = {num_r[cpd_pkg::PROD_W-2:0], 1'b0};
        if (d_trial >= {2'b00, den_r}) begin
          rem_nxt = d_trial - {2'b00, den_r};
          quo_nxt = {quo_r[cpd_pkg::QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt = d_trial;
          quo_nxt = {quo_r[cpd_pkg::QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    sqrt_r <= sqrt_nxt;
    cnt_r  <= cnt_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
  end

  assign rsp.busy   = busy_r;
  assign rsp.done   = done_r;
  assign rsp.result = quo_r;

endmodule
